// ===== rtl/ufc_pkg.sv =====
package ufc_pkg;

  // Default queue depths
  localparam int unsigned TX_DEPTH_DEF = 64;
  localparam int unsigned RX_DEPTH_DEF = 64;

  // Field widths
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FILL_W   = 7;
  localparam int unsigned MARK_W   = 7;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HS_EN     = 2'd2;

  localparam logic [MARK_W-1:0] HIGH_MARK_RST = 7'd48;
  localparam logic [MARK_W-1:0] LOW_MARK_RST  = 7'd16;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUT      = 3'd0,
    REQ_SLOT     = 3'd1,
    REQ_RECV     = 3'd2,
    REQ_GET      = 3'd3,
    REQ_FLUSH_TX = 3'd4,
    REQ_FLUSH_RX = 3'd5
  } req_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_TX_FULL  = 3'd1,
    STAT_RX_EMPTY = 3'd2,
    STAT_RX_ERR   = 3'd3,
    STAT_TX_EMPTY = 3'd4,
    STAT_RTS_HOLD = 3'd5,
    STAT_RX_OVF   = 3'd6
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;   // capture the accepted input transaction
    logic commit;  // apply the operation and load the result register
  } cmd_t;

endpackage

// ===== rtl/ufc_ram.sv =====
module ufc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ufc_ctrl.sv =====
module ufc_ctrl
  import ufc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Output register is free when empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // Sequence one transaction: capture, then commit once the result slot frees
  always_comb begin
    state_d      = state_q;
    cmd_o.latch  = 1'b0;
    cmd_o.commit = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/ufc_dp.sv =====
module ufc_dp
  import ufc_pkg::*;
#(
  parameter int unsigned TX_DEPTH = TX_DEPTH_DEF,
  parameter int unsigned RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [BYTE_W-1:0]     data_byte_i,
  input  logic                  rx_error_i,
  input  logic                  rts_ready_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [BYTE_W-1:0]     out_byte_o,
  output logic                  line_send_o,
  output logic                  host_valid_o,
  output logic                  cts_level_o,
  output logic [FILL_W-1:0]     tx_fill_o,
  output logic [FILL_W-1:0]     rx_fill_o,
  output logic                  tx_active_o
);

  localparam int unsigned TX_PTR_W = $clog2(TX_DEPTH);
  localparam int unsigned RX_PTR_W = $clog2(RX_DEPTH);
  localparam int unsigned TX_CNT_W = $clog2(TX_DEPTH + 1);
  localparam int unsigned RX_CNT_W = $clog2(RX_DEPTH + 1);
  localparam int unsigned TX_EXT_W = (TX_CNT_W > FILL_W) ? TX_CNT_W : FILL_W;
  localparam int unsigned RX_EXT_W = (RX_CNT_W > MARK_W) ? RX_CNT_W : MARK_W;

  localparam logic [TX_PTR_W-1:0] TX_LAST = TX_PTR_W'(TX_DEPTH - 1);
  localparam logic [RX_PTR_W-1:0] RX_LAST = RX_PTR_W'(RX_DEPTH - 1);
  localparam logic [TX_CNT_W-1:0] TX_FULL = TX_CNT_W'(TX_DEPTH);
  localparam logic [RX_CNT_W-1:0] RX_FULL = RX_CNT_W'(RX_DEPTH);

  // Captured input transaction
  logic [REQ_W-1:0]  req_q;
  logic [BYTE_W-1:0] data_q;
  logic              err_q;
  logic              rts_q;

  // Queue state
  logic [TX_PTR_W-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [TX_CNT_W-1:0] tx_cnt_q, tx_cnt_d;
  logic                tx_run_q, tx_run_d;
  logic [RX_PTR_W-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [RX_CNT_W-1:0] rx_cnt_q, rx_cnt_d;
  logic                cts_q, cts_d;

  // Configuration
  logic [MARK_W-1:0] high_mark_q, low_mark_q;
  logic              hs_en_q;

  // Operation results
  status_e           status_d;
  logic [BYTE_W-1:0] obyte_d;
  logic              lsend_d, hvalid_d;
  logic              tx_we, rx_we;
  logic [BYTE_W-1:0] tx_rdata, rx_rdata;
  logic [TX_EXT_W-1:0] tx_cnt_ext;
  logic [RX_EXT_W-1:0] rx_cnt_ext, high_ext, low_ext;

  // Result register
  logic [STATUS_W-1:0] status_q;
  logic [BYTE_W-1:0]   obyte_q;
  logic                lsend_q, hvalid_q, cts_out_q, run_out_q;
  logic [FILL_W-1:0]   tx_fill_q, rx_fill_q;

  // Byte stores, read at the head pointer every cycle
  ufc_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_tail_q),
    .wdata_i (data_q),
    .raddr_i (tx_head_q),
    .rdata_o (tx_rdata)
  );

  ufc_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_tail_q),
    .wdata_i (data_q),
    .raddr_i (rx_head_q),
    .rdata_o (rx_rdata)
  );

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q  <= req_type_i;
      data_q <= data_byte_i;
      err_q  <= rx_error_i;
      rts_q  <= rts_ready_i;
    end
  end

  assign high_ext = RX_EXT_W'(high_mark_q);
  assign low_ext  = RX_EXT_W'(low_mark_q);

  // Apply the captured request to the queues
  always_comb begin
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    tx_cnt_d  = tx_cnt_q;
    tx_run_d  = tx_run_q;
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    rx_cnt_d  = rx_cnt_q;
    cts_d     = cts_q;
    status_d  = STAT_OK;
    obyte_d   = '0;
    lsend_d   = 1'b0;
    hvalid_d  = 1'b0;
    tx_we     = 1'b0;
    rx_we     = 1'b0;
    rx_cnt_ext = RX_EXT_W'(rx_cnt_q);
    unique case (req_e'(req_q))
      REQ_PUT: begin
        if (tx_cnt_q >= TX_FULL) begin
          status_d = STAT_TX_FULL;
        end else begin
          tx_we     = cmd_i.commit;
          tx_tail_d = (tx_tail_q == TX_LAST) ? '0 : tx_tail_q + 1'b1;
          tx_cnt_d  = tx_cnt_q + 1'b1;
          tx_run_d  = 1'b1;
        end
      end
      REQ_SLOT: begin
        if (!rts_q) begin
          status_d = STAT_RTS_HOLD;
        end else if (tx_cnt_q == '0) begin
          tx_run_d = 1'b0;
          status_d = STAT_TX_EMPTY;
        end else begin
          obyte_d   = tx_rdata;
          tx_head_d = (tx_head_q == TX_LAST) ? '0 : tx_head_q + 1'b1;
          tx_cnt_d  = tx_cnt_q - 1'b1;
          lsend_d   = 1'b1;
        end
      end
      REQ_RECV: begin
        if (err_q) begin
          status_d = STAT_RX_ERR;
        end else if (rx_cnt_q >= RX_FULL) begin
          status_d = STAT_RX_OVF;
        end else begin
          rx_we      = cmd_i.commit;
          rx_tail_d  = (rx_tail_q == RX_LAST) ? '0 : rx_tail_q + 1'b1;
          rx_cnt_d   = rx_cnt_q + 1'b1;
          rx_cnt_ext = RX_EXT_W'(rx_cnt_d);
          if (hs_en_q && (rx_cnt_ext >= high_ext)) begin
            cts_d = 1'b0;
          end
        end
      end
      REQ_GET: begin
        if (rx_cnt_q == '0) begin
          status_d = STAT_RX_EMPTY;
        end else begin
          obyte_d    = rx_rdata;
          rx_head_d  = (rx_head_q == RX_LAST) ? '0 : rx_head_q + 1'b1;
          rx_cnt_d   = rx_cnt_q - 1'b1;
          hvalid_d   = 1'b1;
          rx_cnt_ext = RX_EXT_W'(rx_cnt_d);
          if (hs_en_q) begin
            if (rx_cnt_ext <= low_ext) begin
              cts_d = 1'b1;
            end else if (rx_cnt_ext >= high_ext) begin
              cts_d = 1'b0;
            end
          end
        end
      end
      REQ_FLUSH_TX: begin
        tx_head_d = '0;
        tx_tail_d = '0;
        tx_cnt_d  = '0;
        tx_run_d  = 1'b0;
      end
      REQ_FLUSH_RX: begin
        // An empty ring is always at or below the low mark
        rx_head_d  = '0;
        rx_tail_d  = '0;
        rx_cnt_d   = '0;
        rx_cnt_ext = '0;
        cts_d      = 1'b1;
      end
      default: begin
      end
    endcase
    if (!hs_en_q) begin
      cts_d = 1'b1;
    end
  end

  assign tx_cnt_ext = TX_EXT_W'(tx_cnt_d);

  // Queue state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      tx_cnt_q    <= '0;
      tx_run_q    <= 1'b0;
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      rx_cnt_q    <= '0;
      cts_q       <= 1'b1;
      high_mark_q <= HIGH_MARK_RST;
      low_mark_q  <= LOW_MARK_RST;
      hs_en_q     <= 1'b1;
    end else if (cfg_we_i) begin
      priority if (cfg_index_i == CFG_HIGH_MARK) begin
        high_mark_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_LOW_MARK) begin
        low_mark_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_HS_EN) begin
        hs_en_q <= cfg_data_i[0];
        if (!cfg_data_i[0]) begin
          cts_q <= 1'b1;
        end
      end else begin
      end
    end else if (cmd_i.commit) begin
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      tx_cnt_q  <= tx_cnt_d;
      tx_run_q  <= tx_run_d;
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      rx_cnt_q  <= rx_cnt_d;
      cts_q     <= cts_d;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q  <= status_d;
      obyte_q   <= obyte_d;
      lsend_q   <= lsend_d;
      hvalid_q  <= hvalid_d;
      cts_out_q <= cts_d;
      tx_fill_q <= tx_cnt_ext[FILL_W-1:0];
      rx_fill_q <= rx_cnt_ext[FILL_W-1:0];
      run_out_q <= tx_run_d;
    end
  end

  // Report fill after this step for every request type
  always_comb begin
    rx_fill_o = rx_fill_q;
  end

  assign status_o     = status_q;
  assign out_byte_o   = obyte_q;
  assign line_send_o  = lsend_q;
  assign host_valid_o = hvalid_q;
  assign cts_level_o  = cts_out_q;
  assign tx_fill_o    = tx_fill_q;
  assign tx_active_o  = run_out_q;

endmodule

// ===== rtl/uart_fifo_pair_with_flow_control.sv =====
// UART transmit and receive queue pair with RTS/CTS flow control.
// Input channel (in_valid_i / in_stall_o) carries one request transaction:
// host put, transmitter slot, line byte received, host get, or a flush of
// either queue. Every request yields exactly one result transaction on the
// output channel (out_valid_o / out_stall_i) with status, the dequeued byte,
// send/valid flags, the CTS level and both fill levels after the step.
// A request accepted on the input channel is captured in the datapath; its
// result is loaded into the output register once that register frees. A new
// request is stalled until the previous one commits. The registered read port
// of the byte stores is sampled at the head pointer at capture, used at commit.
// If the receiver stalls, the finished result holds in the output register;
// the next request is still taken and waits in the datapath until the output
// register frees, while further requests are stalled.
// Reset clears pointers, counts and the running flag, sets CTS ready and
// loads the marks 48 and 16 with handshake enabled. The byte stores are not
// cleared; the counts never let an unwritten entry be read.
// Configuration writes (cfg_we_i) are taken at any edge and must be issued
// only while no request is in flight.
module uart_fifo_pair_with_flow_control
  import ufc_pkg::*;
#(
  parameter int unsigned TX_DEPTH = TX_DEPTH_DEF,
  parameter int unsigned RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [BYTE_W-1:0]     data_byte_i,
  input  logic                  rx_error_i,
  input  logic                  rts_ready_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [BYTE_W-1:0]     out_byte_o,
  output logic                  line_send_o,
  output logic                  host_valid_o,
  output logic                  cts_level_o,
  output logic [FILL_W-1:0]     tx_fill_o,
  output logic [FILL_W-1:0]     rx_fill_o,
  output logic                  tx_active_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;

  // Transaction sequencing
  ufc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Queues, flow control and result register
  ufc_dp #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .rx_error_i   (rx_error_i),
    .rts_ready_i  (rts_ready_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .status_o     (status_o),
    .out_byte_o   (out_byte_o),
    .line_send_o  (line_send_o),
    .host_valid_o (host_valid_o),
    .cts_level_o  (cts_level_o),
    .tx_fill_o    (tx_fill_o),
    .rx_fill_o    (rx_fill_o),
    .tx_active_o  (tx_active_o)
  );

endmodule
